// ----- src/lug_pkg.sv -----
// ----------------------------------------------------------------------------
// lug_pkg
// Shared types, widths and constants of the LCG uniform/gaussian generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lug_pkg;

  // Largest number of fractions summed for one gaussian sample.
  localparam int MAX_GROUP = 16;

  localparam int VAL_W  = 31;  // LCG state, multiplier, increment, modulus
  localparam int SMP_W  = 32;  // Q16.16 sample, offset, scale
  localparam int FRAC_W = 32;  // Q0.32 fraction
  localparam int GRP_W  = 5;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 32;

  // Sum of up to MAX_GROUP fractions, and the signed deviation built from it.
  localparam int SUM_W  = FRAC_W + $clog2(MAX_GROUP);
  localparam int D_W    = (SUM_W + 1 > FRAC_W + 3) ? SUM_W + 1 : FRAC_W + 3;
  localparam int HI_W   = SMP_W + 1;
  localparam int ACC_W  = HI_W + D_W;
  localparam int PH_W   = ACC_W - FRAC_W;
  localparam int R_W    = PH_W + 1;
  localparam int LEFT_W = $clog2(MAX_GROUP + 1);

  // Step counts of the iterative unit.
  localparam int ALU_CNT_W = 6;
  localparam logic [ALU_CNT_W-1:0] MUL_STEPS  = ALU_CNT_W'(VAL_W);
  localparam logic [ALU_CNT_W-1:0] DIV_STEPS  = ALU_CNT_W'(2 * VAL_W + 1);
  localparam logic [ALU_CNT_W-1:0] FRAC_STEPS = ALU_CNT_W'(FRAC_W);
  localparam logic [ALU_CNT_W-1:0] SMUL_STEPS = ALU_CNT_W'(D_W);

  // Centering term of the gaussian sum: 3.0 in Q.32.
  localparam logic [D_W-1:0] GAUSS_BIAS = D_W'({2'd3, {FRAC_W{1'b0}}});

  // Saturation borders of the signed 32-bit sample.
  localparam logic signed [R_W-1:0] SAT_MAX = R_W'({1'b0, {(SMP_W-1){1'b1}}});
  localparam logic signed [R_W-1:0] SAT_MIN =
    {{(R_W-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};

  // Register reset values.
  localparam logic [MODE_W-1:0]       MODE_RST  = 2'd1;
  localparam logic [VAL_W-1:0]        MULT_RST  = 31'd12312331;
  localparam logic [VAL_W-1:0]        INCR_RST  = 31'd111;
  localparam logic [VAL_W-1:0]        MOD_RST   = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]        SEED_RST  = 31'd13;
  localparam logic [GRP_W-1:0]        GRP_RST   = 5'd6;
  localparam logic signed [SMP_W-1:0] OFFS_RST  = 32'sd0;
  localparam logic signed [SMP_W-1:0] SCALE_RST = 32'sd65536;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW     = 2'd0,
    MODE_UNIFORM = 2'd1,
    MODE_GAUSS   = 2'd2
  } mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_MULT   = 3'd1,
    REG_INCR   = 3'd2,
    REG_MOD    = 3'd3,
    REG_SEED   = 3'd4,
    REG_GROUP  = 3'd5,
    REG_OFFSET = 3'd6,
    REG_SCALE  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ADV,    // x' = (a*x + c) mod m
    OP_FRAC,   // floor(x * 2^32 / m)
    OP_SCALE   // floor(scale * d / 2^32)
  } alu_op_e;

  typedef enum logic [2:0] {
    AP_IDLE,
    AP_MUL,
    AP_ADDC,
    AP_DIV,
    AP_SMUL
  } alu_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_FRAC,
    ST_SCALE,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic                    start;
    alu_op_e                 op;
    logic [VAL_W-1:0]        x;
    logic signed [D_W-1:0]   d;
  } alu_req_t;

  typedef struct packed {
    logic                    done;
    logic                    busy;
    logic [VAL_W-1:0]        rem;
    logic [FRAC_W-1:0]       quo;
    logic signed [PH_W-1:0]  prod;
  } alu_rsp_t;

endpackage

// ----- src/lug_alu.sv -----
// ----------------------------------------------------------------------------
// lug_alu
// Iterative shift/add unit: LCG step, fraction division and scaling multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lug_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lug_pkg::alu_req_t             req_i,
  input  logic [lug_pkg::VAL_W-1:0]     mult_i,
  input  logic [lug_pkg::VAL_W-1:0]     incr_i,
  input  logic [lug_pkg::VAL_W-1:0]     modulus_i,
  input  logic signed [lug_pkg::SMP_W-1:0] scale_i,
  output lug_pkg::alu_rsp_t             rsp_o
);
  import lug_pkg::*;

  localparam int DIVD_W = 2 * VAL_W + 1;

  alu_phase_e             phase_q, phase_d;
  logic [ALU_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic                   last;

  logic [ACC_W-1:0]       acc_q;
  logic [VAL_W-1:0]       rem_q;

  logic [VAL_W+1:0]       mul_sum;
  logic [DIVD_W-1:0]      addc_sum;
  logic [VAL_W:0]         rem_sh;
  logic [VAL_W:0]         rem_diff;
  logic                   ge;
  logic [VAL_W-1:0]       rem_nx;
  logic signed [HI_W:0]   hi_ext;
  logic signed [HI_W:0]   s_ext;
  logic signed [HI_W:0]   smul_sum;

  assign last = (cnt_q == ALU_CNT_W'(1));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      AP_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_ADV:   phase_d = AP_MUL;
            OP_FRAC:  phase_d = AP_DIV;
            OP_SCALE: phase_d = AP_SMUL;
          endcase
        end
      end
      AP_MUL:  if (last) phase_d = AP_ADDC;
      AP_ADDC: phase_d = AP_DIV;
      AP_DIV:  if (last) phase_d = AP_IDLE;
      AP_SMUL: if (last) phase_d = AP_IDLE;
    endcase
  end

  // Step counter and completion
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    unique case (phase_q)
      AP_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_ADV:   cnt_d = MUL_STEPS;
            OP_FRAC:  cnt_d = FRAC_STEPS;
            OP_SCALE: cnt_d = SMUL_STEPS;
          endcase
        end
      end
      AP_ADDC: cnt_d = DIV_STEPS;
      AP_MUL:  cnt_d = cnt_q - ALU_CNT_W'(1);
      AP_DIV, AP_SMUL: begin
        cnt_d  = cnt_q - ALU_CNT_W'(1);
        done_d = last;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= AP_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath arithmetic
  always_comb begin
    mul_sum  = {1'b0, acc_q[DIVD_W-1:VAL_W]}
             + {2'b00, (acc_q[0] ? mult_i : {VAL_W{1'b0}})};
    addc_sum = acc_q[DIVD_W-1:0] + DIVD_W'(incr_i);
    rem_sh   = {rem_q, acc_q[DIVD_W-1]};
    rem_diff = rem_sh - {1'b0, modulus_i};
    ge       = (rem_sh >= {1'b0, modulus_i});
    rem_nx   = ge ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
    hi_ext   = {acc_q[ACC_W-1], acc_q[ACC_W-1:D_W]};
    s_ext    = {{2{scale_i[SMP_W-1]}}, scale_i};
    if (!acc_q[0]) begin
      smul_sum = hi_ext;
    end else if (last) begin
      // sign bit of d carries negative weight
      smul_sum = hi_ext - s_ext;
    end else begin
      smul_sum = hi_ext + s_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      AP_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_ADV:   acc_q <= ACC_W'(req_i.x);
            OP_FRAC: begin
              acc_q <= '0;
              rem_q <= req_i.x;
            end
            OP_SCALE: acc_q <= {{HI_W{1'b0}}, req_i.d};
          endcase
        end
      end
      AP_MUL:  acc_q <= ACC_W'({mul_sum, acc_q[VAL_W-1:1]});
      AP_ADDC: begin
        acc_q <= ACC_W'(addc_sum);
        rem_q <= '0;
      end
      AP_DIV: begin
        acc_q <= ACC_W'({acc_q[DIVD_W-2:0], ge});
        rem_q <= rem_nx;
      end
      AP_SMUL: acc_q <= {smul_sum, acc_q[D_W-1:1]};
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = (phase_q != AP_IDLE);
  assign rsp_o.rem  = rem_q;
  assign rsp_o.quo  = acc_q[FRAC_W-1:0];
  assign rsp_o.prod = acc_q[ACC_W-1:FRAC_W];

endmodule

// ----- src/lcg_uniform_gaussian_generator.sv -----
// ----------------------------------------------------------------------------
// lcg_uniform_gaussian_generator
// Streaming mixed LCG with raw, uniform Q16.16 and central-limit gaussian
// Q16.16 outputs.
//
// Each request advances the generator state x' = (a*x + c) mod m, reloading
// the seed first when restart is set, and returns one result: the first new
// state, the sample of the selected mode and a saturation flag. LCG steps,
// fractions and the scaling multiply run on one shared iterative unit, one bit
// per cycle: an LCG step is a shift-add multiply, one add of the increment and
// a restoring division, a fraction x*2^32/m is a division, and the final
// scale*d is a signed shift-add multiply. A raw-mode request runs one LCG
// step, a uniform one also a fraction and the scaling multiply, and a
// gaussian one an LCG step and a fraction for each of n fractions in its
// group (six by default), then the scaling multiply. The block takes one
// request at a time; the result sits in an output register, so the next
// request is taken while the previous result still waits downstream.
// Registers are written only while the block is idle and no request is
// offered; a modulus below two acts as two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_uniform_gaussian_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             restart_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lug_pkg::VAL_W-1:0]        raw_value_o,
  output logic signed [lug_pkg::SMP_W-1:0] sample_o,
  output logic                             saturated_o,
  // register write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lug_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [lug_pkg::CFG_W-1:0]        cfg_data_i
);
  import lug_pkg::*;

  // Configuration registers
  logic [MODE_W-1:0]       mode_q;
  logic [VAL_W-1:0]        mult_q;
  logic [VAL_W-1:0]        incr_q;
  logic [VAL_W-1:0]        modulus_q;
  logic [VAL_W-1:0]        seed_q;
  logic [GRP_W-1:0]        group_q;
  logic signed [SMP_W-1:0] offset_q;
  logic signed [SMP_W-1:0] scale_q;

  // Sequencer state
  seq_state_e              state_q, state_d;
  logic [VAL_W-1:0]        x_q;        // generator state
  logic [LEFT_W-1:0]       left_q;     // fractions still to draw
  logic                    first_q;    // next step gives raw_value
  logic [SUM_W-1:0]        sum_q;

  // Pending result
  logic [VAL_W-1:0]        raw_q;
  logic signed [SMP_W-1:0] smp_q;
  logic                    sat_q;

  // Output register
  logic                    out_valid_q;
  logic [VAL_W-1:0]        out_raw_q;
  logic signed [SMP_W-1:0] out_smp_q;
  logic                    out_sat_q;

  alu_req_t                alu_req;
  alu_rsp_t                alu_rsp;

  logic                    in_accept;
  logic                    out_free;
  logic                    frac_mode;
  logic                    more;
  logic [VAL_W-1:0]        eff_mod;
  logic [LEFT_W-1:0]       n_init;
  logic [SUM_W-1:0]        sum_next;
  logic signed [D_W-1:0]   d_val;
  logic signed [R_W-1:0]   r_full;
  logic signed [SMP_W-1:0] r_sat;
  logic                    r_clip;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  // Hold off register writes while a request is offered, so a request never
  // starts in the same cycle its settings change.
  assign cfg_ready_o = (state_q == ST_IDLE) && !in_valid_i;

  assign frac_mode = (mode_q == MODE_UNIFORM) || (mode_q == MODE_GAUSS);
  assign more      = (mode_q == MODE_GAUSS) && (left_q > LEFT_W'(1));

  // Modulus below two acts as two.
  assign eff_mod = (modulus_q[VAL_W-1:1] == '0) ? VAL_W'(2) : modulus_q;

  // Clamp the group size to 1..MAX_GROUP.
  always_comb begin
    if (group_q == '0) begin
      n_init = LEFT_W'(1);
    end else if (int'(group_q) > MAX_GROUP) begin
      n_init = LEFT_W'(MAX_GROUP);
    end else begin
      n_init = LEFT_W'(group_q);
    end
  end

  // Deviation handed to the scaling multiply: the fraction sum, centered by
  // three in gaussian mode.
  assign sum_next = sum_q + SUM_W'(alu_rsp.quo);
  assign d_val    = $signed(D_W'(sum_next)
                  - ((mode_q == MODE_GAUSS) ? GAUSS_BIAS : {D_W{1'b0}}));

  // Add offset to the floored product, then saturate.
  always_comb begin
    r_full = R_W'($signed(offset_q)) + R_W'($signed(alu_rsp.prod));
    if (r_full > SAT_MAX) begin
      r_sat  = SAT_MAX[SMP_W-1:0];
      r_clip = 1'b1;
    end else if (r_full < SAT_MIN) begin
      r_sat  = SAT_MIN[SMP_W-1:0];
      r_clip = 1'b1;
    end else begin
      r_sat  = r_full[SMP_W-1:0];
      r_clip = 1'b0;
    end
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RST;
      mult_q    <= MULT_RST;
      incr_q    <= INCR_RST;
      modulus_q <= MOD_RST;
      seed_q    <= SEED_RST;
      group_q   <= GRP_RST;
      offset_q  <= OFFS_RST;
      scale_q   <= SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_MODE:   mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_MULT:   mult_q    <= cfg_data_i[VAL_W-1:0];
        REG_INCR:   incr_q    <= cfg_data_i[VAL_W-1:0];
        REG_MOD:    modulus_q <= cfg_data_i[VAL_W-1:0];
        REG_SEED:   seed_q    <= cfg_data_i[VAL_W-1:0];
        REG_GROUP:  group_q   <= cfg_data_i[GRP_W-1:0];
        REG_OFFSET: offset_q  <= $signed(cfg_data_i[SMP_W-1:0]);
        REG_SCALE:  scale_q   <= $signed(cfg_data_i[SMP_W-1:0]);
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_ADV;
      ST_ADV:   if (alu_rsp.done) state_d = frac_mode ? ST_FRAC : ST_DONE;
      ST_FRAC:  if (alu_rsp.done) state_d = more ? ST_ADV : ST_SCALE;
      ST_SCALE: if (alu_rsp.done) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
    endcase
  end

  // Unit commands: chain the next operation in the cycle the previous ends.
  always_comb begin
    alu_req       = '0;
    alu_req.op    = OP_ADV;
    alu_req.x     = x_q;
    alu_req.d     = d_val;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_ADV;
          alu_req.x     = restart_i ? seed_q : x_q;
        end
      end
      ST_ADV: begin
        if (alu_rsp.done && frac_mode) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_FRAC;
          alu_req.x     = alu_rsp.rem;
        end
      end
      ST_FRAC: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = more ? OP_ADV : OP_SCALE;
        end
      end
      ST_SCALE, ST_DONE: ;
    endcase
  end

  lug_alu u_alu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (alu_req),
    .mult_i    (mult_q),
    .incr_i    (incr_q),
    .modulus_i (eff_mod),
    .scale_i   (scale_q),
    .rsp_o     (alu_rsp)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= SEED_RST;
      left_q      <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        left_q  <= n_init;
        first_q <= 1'b1;
      end
      if (state_q == ST_ADV && alu_rsp.done) begin
        x_q     <= alu_rsp.rem;
        first_q <= 1'b0;
      end
      if (state_q == ST_FRAC && alu_rsp.done) begin
        left_q <= left_q - LEFT_W'(1);
      end
      // Load a finished result, or drop the valid once it is taken.
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sum_q <= '0;
    end
    if (state_q == ST_ADV && alu_rsp.done && first_q) begin
      // Raw mode result; overwritten by the scaled sample in other modes.
      raw_q <= alu_rsp.rem;
      smp_q <= $signed(SMP_W'(alu_rsp.rem));
      sat_q <= 1'b0;
    end
    if (state_q == ST_FRAC && alu_rsp.done) begin
      sum_q <= sum_next;
    end
    if (state_q == ST_SCALE && alu_rsp.done) begin
      smp_q <= r_sat;
      sat_q <= r_clip;
    end
    if (state_q == ST_DONE && out_free) begin
      out_raw_q <= raw_q;
      out_smp_q <= smp_q;
      out_sat_q <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign raw_value_o = out_raw_q;
  assign sample_o    = out_smp_q;
  assign saturated_o = out_sat_q;

`ifndef NO_ASSERTIONS
  // A new result appears only out of the completion state.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result presented outside completion");

  // The unit is never started while still iterating.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_rsp.busy)
    else $error("unit started while busy");

  // An accepted request always launches an LCG step.
  a_accept_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_ADV) && alu_rsp.busy)
    else $error("accepted request did not start an LCG step");

  // Drawing a fraction needs at least one left in the group.
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FRAC) |-> (left_q != '0))
    else $error("fraction drawn with empty group count");
`endif

endmodule
